// File: rtl/core/tvi_pkg.sv
// Shared constants for the trilinear voxel interpolator.
package tvi_pkg;

  localparam int FRAC_BITS_DEF = 16;  // default fraction width, Q0.16
  localparam int FRAC_W        = 16;  // width of the fraction ports
  localparam int VOXEL_W       = 8;   // width of one voxel and of the result
  localparam int PIPE_DEPTH    = 4;   // register stages from start to out_valid

endpackage

// File: rtl/core/trilinear_voxel_interpolator_core.sv
// Top level of the trilinear voxel interpolator: four-stage blend pipeline.
//
// A transfer is taken on every rising edge with start high and busy is low; busy is high
// while reset is held and in the cycle that follows it, so the block takes one cube per
// clock. Each result appears on out_interpolated_value with out_valid high for exactly one
// cycle, in order; the receiver cannot hold it off and nothing in the block waits on it.
// Stage 1 blends along x (four lanes), stage 2 along y (two lanes), stage 3 along z with
// the y sums split into high and low halves so no multiplier exceeds about 25 x 17 bits,
// and stage 4 adds the halves and keeps the integer part (truncation, never saturation:
// the weights sum to one). Only the low FRAC_BITS bits of each fraction are used when
// FRAC_BITS is below 16; above 16 the fraction ports are zero-extended.
module trilinear_voxel_interpolator_core
  import tvi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FRAC_W-1:0]  in_frac_z,
  input  logic [FRAC_W-1:0]  in_frac_y,
  input  logic [FRAC_W-1:0]  in_frac_x,
  input  logic [VOXEL_W-1:0] in_voxel_000,
  input  logic [VOXEL_W-1:0] in_voxel_001,
  input  logic [VOXEL_W-1:0] in_voxel_010,
  input  logic [VOXEL_W-1:0] in_voxel_011,
  input  logic [VOXEL_W-1:0] in_voxel_100,
  input  logic [VOXEL_W-1:0] in_voxel_101,
  input  logic [VOXEL_W-1:0] in_voxel_110,
  input  logic [VOXEL_W-1:0] in_voxel_111,
  output logic               out_valid,
  output logic [VOXEL_W-1:0] out_interpolated_value
);

  localparam int F  = FRAC_BITS;
  localparam int XW = VOXEL_W + F;      // x stage, scale 2^F
  localparam int YW = VOXEL_W + 2 * F;  // y stage, scale 2^2F
  localparam int HW = VOXEL_W + 2 * F;  // z stage high half
  localparam int LW = 2 * F;            // z stage low half
  localparam int SW = YW + 1;           // final sum

  // ---- handshake ----
  logic busy_r, busy_nxt;
  logic in_acc;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  assign busy     = busy_r;
  assign in_acc   = start && !busy_r;
  assign busy_nxt = 1'b0;
  assign vld_nxt  = {vld_r[PIPE_DEPTH-2:0], in_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // ---- fraction alignment to FRAC_BITS ----
  logic [F-1:0] fz, fy, fx;
  generate
    if (F <= FRAC_W) begin : g_frac_trunc
      assign fz = in_frac_z[F-1:0];
      assign fy = in_frac_y[F-1:0];
      assign fx = in_frac_x[F-1:0];
    end else begin : g_frac_ext
      assign fz = {{(F-FRAC_W){1'b0}}, in_frac_z};
      assign fy = {{(F-FRAC_W){1'b0}}, in_frac_y};
      assign fx = {{(F-FRAC_W){1'b0}}, in_frac_x};
    end
  endgenerate

  // fractions travel alongside the blends that still need them
  logic [F-1:0] fz1_r, fy1_r, fz2_r;
  always_ff @(posedge clk) begin
    fz1_r <= fz;
    fy1_r <= fy;
    fz2_r <= fz1_r;
  end

  // ---- stage 1: x blends ----
  logic [XW-1:0] x0_r, x1_r, x2_r, x3_r;
  tvi_lerp #(.VAL_W(VOXEL_W), .FB(F)) u_x0 (
    .clk(clk), .a(in_voxel_000), .b(in_voxel_001), .f(fx), .res_r(x0_r));
  tvi_lerp #(.VAL_W(VOXEL_W), .FB(F)) u_x1 (
    .clk(clk), .a(in_voxel_010), .b(in_voxel_011), .f(fx), .res_r(x1_r));
  tvi_lerp #(.VAL_W(VOXEL_W), .FB(F)) u_x2 (
    .clk(clk), .a(in_voxel_100), .b(in_voxel_101), .f(fx), .res_r(x2_r));
  tvi_lerp #(.VAL_W(VOXEL_W), .FB(F)) u_x3 (
    .clk(clk), .a(in_voxel_110), .b(in_voxel_111), .f(fx), .res_r(x3_r));

  // ---- stage 2: y blends ----
  logic [YW-1:0] y0_r, y1_r;
  tvi_lerp #(.VAL_W(XW), .FB(F)) u_y0 (
    .clk(clk), .a(x0_r), .b(x1_r), .f(fy1_r), .res_r(y0_r));
  tvi_lerp #(.VAL_W(XW), .FB(F)) u_y1 (
    .clk(clk), .a(x2_r), .b(x3_r), .f(fy1_r), .res_r(y1_r));

  // ---- stage 3: z blend, split at bit F to keep the multipliers narrow ----
  logic [HW-1:0] zh_r;
  logic [LW-1:0] zl_r;
  tvi_lerp #(.VAL_W(YW - F), .FB(F)) u_zh (
    .clk(clk), .a(y0_r[YW-1:F]), .b(y1_r[YW-1:F]), .f(fz2_r), .res_r(zh_r));
  tvi_lerp #(.VAL_W(F), .FB(F)) u_zl (
    .clk(clk), .a(y0_r[F-1:0]), .b(y1_r[F-1:0]), .f(fz2_r), .res_r(zl_r));

  // ---- stage 4: recombine, keep integer part ----
  logic [SW-1:0]      tot;
  logic [VOXEL_W-1:0] res_r, res_nxt;

  assign tot     = {1'b0, zh_r} + {{(SW-F){1'b0}}, zl_r[LW-1:F]};
  assign res_nxt = tot[2*F +: VOXEL_W];

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid              = vld_r[PIPE_DEPTH-1];
  assign out_interpolated_value = res_r;

  // ---- checks ----
  // every transfer yields exactly one result at the pipeline output
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##PIPE_DEPTH out_valid)
    else $error("transfer produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, PIPE_DEPTH))
    else $error("result without a matching transfer");

  // busy only in the first cycle after reset
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

  // a cube of equal corners interpolates to that corner, whatever the weights
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_voxel_000 == in_voxel_001 && in_voxel_000 == in_voxel_010
     && in_voxel_000 == in_voxel_011 && in_voxel_000 == in_voxel_100
     && in_voxel_000 == in_voxel_101 && in_voxel_000 == in_voxel_110
     && in_voxel_000 == in_voxel_111)
    |-> ##PIPE_DEPTH (out_interpolated_value == $past(in_voxel_000, PIPE_DEPTH)))
    else $error("flat cube not reproduced");

endmodule

// File: rtl/core/tvi_lerp.sv
// One registered axis blend: a*(1-f) + b*f at scale 2^FB, exact.
module tvi_lerp #(
  parameter int VAL_W = 8,
  parameter int FB    = 16
) (
  input  logic                  clk,
  input  logic [VAL_W-1:0]      a,
  input  logic [VAL_W-1:0]      b,
  input  logic [FB-1:0]         f,
  output logic [VAL_W+FB-1:0]   res_r
);

  localparam int PW = VAL_W + FB + 2;

  logic signed [VAL_W:0]   diff;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    base;
  logic signed [PW-1:0]    sum;
  logic [VAL_W+FB-1:0]     res_nxt;

  // a*2^FB + (b-a)*f: one signed multiply; the total is never negative
  assign diff    = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod    = PW'(diff) * PW'($signed({1'b0, f}));
  assign base    = $signed({2'b00, a, {FB{1'b0}}});
  assign sum     = base + prod;
  assign res_nxt = sum[VAL_W+FB-1:0];

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: bench/tvi_blend_checker.sv
`timescale 1ns / 100ps
// Watches the interpolator channels, predicts each blended voxel and compares the results.
module tvi_blend_checker
  import tvi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [FRAC_W-1:0]       in_frac_z,
  input  logic [FRAC_W-1:0]       in_frac_y,
  input  logic [FRAC_W-1:0]       in_frac_x,
  input  logic [7:0][VOXEL_W-1:0] in_corners,  // index bits are z,y,x offsets
  input  logic                    out_valid,
  input  logic [VOXEL_W-1:0]      out_interpolated_value,
  output int                      fail_count,
  output int                      pending,
  output int                      checked
);

  localparam logic [127:0] ONE_W     = 128'd1 << FRAC_BITS;
  localparam logic [127:0] FRAC_MASK = ONE_W - 128'd1;

  logic [VOXEL_W-1:0] expected_values[$];

  // Exact weighted corner sum, truncated; wide enough for FRAC_BITS up to 40.
  function automatic logic [VOXEL_W-1:0] blend_cube(
    input logic [FRAC_W-1:0]       fz_in,
    input logic [FRAC_W-1:0]       fy_in,
    input logic [FRAC_W-1:0]       fx_in,
    input logic [7:0][VOXEL_W-1:0] corners
  );
    logic [127:0] fz, fy, fx, wz, wy, wx, acc, val;
    int k;
    fz  = {112'd0, fz_in} & FRAC_MASK;
    fy  = {112'd0, fy_in} & FRAC_MASK;
    fx  = {112'd0, fx_in} & FRAC_MASK;
    acc = '0;
    for (k = 0; k < 8; k++) begin
      wz  = k[2] ? fz : ONE_W - fz;
      wy  = k[1] ? fy : ONE_W - fy;
      wx  = k[0] ? fx : ONE_W - fx;
      acc = acc + {120'd0, corners[3'(k)]} * wz * wy * wx;
    end
    val = acc >> (3 * FRAC_BITS);
    return val[VOXEL_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [VOXEL_W-1:0] want;
    if (!rst_n) begin
      expected_values.delete();
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_values.size() == 0) begin
          $error("interpolated_value: no transfer outstanding, actual %0d",
                 out_interpolated_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_values.pop_front();
          checked <= checked + 1;
          if (out_interpolated_value !== want) begin
            $error("interpolated_value: expected %0d, actual %0d",
                   want, out_interpolated_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_values.push_back(blend_cube(in_frac_z, in_frac_y, in_frac_x, in_corners));
      pending <= expected_values.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the trilinear voxel interpolator core.
module testbench;
  import tvi_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int RANDOM_CUBES = 800;
  // a limit far above what ~820 transfers with idle gaps between some of them need
  localparam int CYCLE_LIMIT = 100000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [FRAC_W-1:0]       in_frac_z, in_frac_y, in_frac_x;
  logic [7:0][VOXEL_W-1:0] corners;  // corners[zyx] drives in_voxel_zyx
  logic                    out_valid;
  logic [VOXEL_W-1:0]      out_interpolated_value;

  int  fail_count, pending, checked;
  int  cycles;
  int  sent;
  bit  steady;  // no idle gaps while set

  trilinear_voxel_interpolator_core #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_frac_z              (in_frac_z),
    .in_frac_y              (in_frac_y),
    .in_frac_x              (in_frac_x),
    .in_voxel_000           (corners[0]),
    .in_voxel_001           (corners[1]),
    .in_voxel_010           (corners[2]),
    .in_voxel_011           (corners[3]),
    .in_voxel_100           (corners[4]),
    .in_voxel_101           (corners[5]),
    .in_voxel_110           (corners[6]),
    .in_voxel_111           (corners[7]),
    .out_valid              (out_valid),
    .out_interpolated_value (out_interpolated_value)
  );

  tvi_blend_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_frac_z              (in_frac_z),
    .in_frac_y              (in_frac_y),
    .in_frac_x              (in_frac_x),
    .in_corners             (corners),
    .out_valid              (out_valid),
    .out_interpolated_value (out_interpolated_value),
    .fail_count             (fail_count),
    .pending                (pending),
    .checked                (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One transfer. About a third of the time the sender idles first,
  // with junk on the data ports so the block must ignore it while start is low.
  task automatic send_cube(input logic [FRAC_W-1:0] fz, input logic [FRAC_W-1:0] fy,
                           input logic [FRAC_W-1:0] fx,
                           input logic [7:0][VOXEL_W-1:0] cube);
    if (!steady && $urandom_range(0, 99) < 32) begin
      start     <= 1'b0;
      in_frac_z <= FRAC_W'($urandom);
      in_frac_y <= FRAC_W'($urandom);
      in_frac_x <= FRAC_W'($urandom);
      corners   <= {$urandom, $urandom};
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start     <= 1'b1;
    in_frac_z <= fz;
    in_frac_y <= fy;
    in_frac_x <= fx;
    corners   <= cube;
    // busy is read as sampled at the edge, so the loop exits on the accepting edge
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Sender holds off until every outstanding transfer has produced its result.
  // The first edge lets the count take in the transfer accepted just before.
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random fraction: full range in three of eight picks, else an edge value or a tiny/near-one one.
  function automatic logic [FRAC_W-1:0] pick_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return FRAC_W'($urandom_range(0, 255));
      4:       return 16'hFFFF - FRAC_W'($urandom_range(0, 255));
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0][VOXEL_W-1:0] cube;
    logic [VOXEL_W-1:0]      level;
    int k, n;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_frac_z <= '0;
    in_frac_y <= '0;
    in_frac_x <= '0;
    corners   <= '0;
    cycles    <= 0;
    sent      = 0;
    steady    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed cubes ----
    // all zero, and all full scale with the largest fractions
    send_cube(16'h0000, 16'h0000, 16'h0000, '0);
    send_cube(16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
    // ramp across the corners: zero fractions give the near corner outright,
    // the largest fractions lean almost entirely on the far corner
    cube = {8'd252, 8'd216, 8'd180, 8'd144, 8'd108, 8'd72, 8'd36, 8'd0};
    send_cube(16'h0000, 16'h0000, 16'h0000, cube);
    send_cube(16'hFFFF, 16'hFFFF, 16'hFFFF, cube);
    // one hot corner at a time, fractions steered towards it
    for (k = 0; k < 8; k++) begin
      cube          = '0;
      cube[3'(k)]   = 8'hFF;
      send_cube(k[2] ? 16'hFFFF : 16'h0000, k[1] ? 16'hFFFF : 16'h0000,
                k[0] ? 16'hFFFF : 16'h0000, cube);
    end
    // half-way fractions and alternating bit patterns
    cube = {8'd252, 8'd216, 8'd180, 8'd144, 8'd108, 8'd72, 8'd36, 8'd0};
    send_cube(16'h8000, 16'h8000, 16'h8000, cube);
    send_cube(16'hAAAA, 16'h5555, 16'hFFFF, {4{8'hAA, 8'h55}});
    send_cube(16'h5555, 16'hAAAA, 16'h0001, {4{8'h55, 8'hAA}});
    // smallest non-zero fractions against a dark near corner
    send_cube(16'h0001, 16'h0001, 16'h0001, {{7{8'hFF}}, 8'h00});

    // ---- random cubes ----
    for (n = 0; n < RANDOM_CUBES; n++) begin
      // a long stretch at full rate, one transfer per clock
      steady = (n >= 300 && n < 500);
      if (n == 150 || n == 620) drain_pipe();
      case ($urandom_range(0, 9))
        0: begin  // uniform cube: result must equal the common level
          level = VOXEL_W'($urandom);
          cube  = {8{level}};
        end
        1: cube = {$urandom, $urandom} & {8{8'hFF}} & {8{$urandom_range(0, 1) ? 8'hFF : 8'h00}};
        2: begin  // each corner black or white
          for (k = 0; k < 8; k++) cube[3'(k)] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        3: begin  // single bright corner in a dark cube
          cube = '0;
          cube[3'($urandom_range(0, 7))] = VOXEL_W'($urandom_range(1, 255));
        end
        default: cube = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 1))
        send_cube(pick_frac(), pick_frac(), pick_frac(), cube);
      else
        send_cube(FRAC_W'($urandom), FRAC_W'($urandom), FRAC_W'($urandom), cube);
    end

    // ---- wind down ----
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let any stray strobe surface before the verdict
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("covered %0d cubes (16 directed, %0d random) with idle gaps, a full-rate run",
             sent, RANDOM_CUBES);
    $display("and two drain pauses; %0d blended values checked, %0d mismatches",
             checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: trilinear_voxel_interpolator_core.f
rtl/core/tvi_pkg.sv
rtl/core/tvi_lerp.sv
rtl/core/trilinear_voxel_interpolator_core.sv
bench/tvi_blend_checker.sv
bench/testbench.sv
